### rtl/gbd_pkg.sv
// ----------------------------------------------------------------------------
// gbd_pkg
// Shared types and codes of the Golomb bit decoder.
// ----------------------------------------------------------------------------
package gbd_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGN_MODE = 2'd1;

  // result error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_TRUNC = 2'd1;
  localparam logic [1:0] ERR_OVF   = 2'd2;

  // reset value of the divisor register
  localparam int DIVISOR_RESET = 3;

  // codeword-complete event between the decoder core and the output stage
  typedef struct packed {
    logic valid;
    logic trunc;
    logic ovf;
  } gbd_ev_t;

endpackage

### rtl/gbd_cfg.sv
// ----------------------------------------------------------------------------
// gbd_cfg
// Configuration registers; derives m, k = floor(log2 m) and u = 2^(k+1) - m
// at write time so the decoder core sees them ready-made.
// ----------------------------------------------------------------------------
module gbd_cfg
  import gbd_pkg::*;
#(
  parameter int DIVISOR_BITS = 16,
  parameter int CW           = $clog2(DIVISOR_BITS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIVISOR_BITS-1:0] cfg_data,
  output logic [DIVISOR_BITS-1:0] m_o,
  output logic [CW-1:0]           k_o,
  output logic [DIVISOR_BITS-1:0] u_o,
  output logic                    sign_mode_o
);

  localparam int DB = DIVISOR_BITS;

  logic [DB-1:0] m_r, m_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [DB-1:0] u_r, u_nxt;
  logic          sign_r;
  logic [DB:0]   pow_k1;
  logic          wr;

  function automatic logic [CW-1:0] flog2(input logic [DB-1:0] m);
    logic [CW-1:0] k;
    k = '0;
    for (int i = 0; i < DB; i++) begin
      if (m[i]) k = i[CW-1:0];
    end
    return k;
  endfunction

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_comb begin
    // a divisor of zero decodes as one
    m_nxt  = (cfg_data == '0) ? DB'(1) : cfg_data;
    k_nxt  = flog2(m_nxt);
    // widen the shift amount so k + 1 does not wrap at the top k
    pow_k1 = (DB+1)'(1) << ({1'b0, k_nxt} + (CW+1)'(1));
    u_nxt  = DB'(pow_k1 - {1'b0, m_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r    <= DB'(DIVISOR_RESET);
      k_r    <= CW'(1);
      u_r    <= DB'(1);
      sign_r <= 1'b1;
    end else if (wr) begin
      if (cfg_index == CFG_DIVISOR) begin
        m_r <= m_nxt;
        k_r <= k_nxt;
        u_r <= u_nxt;
      end else if (cfg_index == CFG_SIGN_MODE) begin
        sign_r <= cfg_data[0];
      end
    end
  end

  assign m_o         = m_r;
  assign k_o         = k_r;
  assign u_o         = u_r;
  assign sign_mode_o = sign_r;

endmodule

### rtl/gbd_core.sv
// ----------------------------------------------------------------------------
// gbd_core
// Codeword state machine: unary run, plain remainder bits, extra bit. Emits a
// registered event with N = q*m + r when a codeword completes or is cut off.
// ----------------------------------------------------------------------------
module gbd_core
  import gbd_pkg::*;
#(
  parameter int MAPPED_BITS  = 17,
  parameter int DIVISOR_BITS = 16,
  parameter int CW           = $clog2(DIVISOR_BITS),
  parameter int QW           = ((MAPPED_BITS > DIVISOR_BITS) ? MAPPED_BITS : DIVISOR_BITS) + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_code_bit,
  input  logic                    in_stream_end,
  input  logic [DIVISOR_BITS-1:0] m_i,
  input  logic [CW-1:0]           k_i,
  input  logic [DIVISOR_BITS-1:0] u_i,
  input  logic                    ev_ready,
  output gbd_ev_t                 ev_o,
  output logic [QW-1:0]           ev_n_o
);

  localparam int DB = DIVISOR_BITS;
  localparam int MB = MAPPED_BITS;
  localparam int RW = DB - 1;

  localparam logic [1:0] PH_UNARY = 2'd0;
  localparam logic [1:0] PH_REM   = 2'd1;
  localparam logic [1:0] PH_EXTRA = 2'd2;

  logic [1:0]    phase_r, phase_nxt;
  logic [QW-1:0] qs_r, qs_nxt;
  logic          ovf_r, ovf_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  gbd_ev_t       ev_r, ev_nxt;
  logic [QW-1:0] ev_n_r, ev_n_nxt;

  logic          accept;
  logic          fin;
  logic          trunc;
  logic [DB-1:0] r_fin;
  logic [QW-1:0] qs_add;
  logic [DB-1:0] rem_sh;
  logic [DB-1:0] rem_sub;
  logic [DB-1:0] v_new;
  logic [CW-1:0] cnt_inc;

  // hold the input while a finished event cannot move on
  assign in_stall = ev_r.valid && !ev_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    phase_nxt = phase_r;
    qs_nxt    = qs_r;
    ovf_nxt   = ovf_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    fin       = 1'b0;
    trunc     = 1'b0;
    r_fin     = '0;
    qs_add    = qs_r + QW'(m_i);
    rem_sh    = {rem_r, in_code_bit};
    rem_sub   = rem_sh - u_i;
    v_new     = {1'b0, rem_sh[RW-1:0]};
    cnt_inc   = cnt_r + CW'(1);

    if (accept) begin
      if (in_stream_end) begin
        // end marker while idle between codewords is dropped
        if (!(phase_r == PH_UNARY && qs_r == '0 && !ovf_r)) begin
          fin   = 1'b1;
          trunc = 1'b1;
        end
      end else begin
        case (phase_r)
          PH_UNARY: begin
            if (in_code_bit) begin
              if (!ovf_r) begin
                qs_nxt  = qs_add;
                ovf_nxt = |qs_add[QW-1:MB];
              end
            end else begin
              rem_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_REM;
              // no plain bits: r = 0, always below u
              if (k_i == '0) fin = 1'b1;
            end
          end
          PH_REM: begin
            rem_nxt = rem_sh[RW-1:0];
            cnt_nxt = cnt_inc;
            if (cnt_inc >= k_i) begin
              if (v_new < u_i) begin
                fin   = 1'b1;
                r_fin = v_new;
              end else begin
                phase_nxt = PH_EXTRA;
              end
            end
          end
          PH_EXTRA: begin
            fin   = 1'b1;
            r_fin = (rem_sh >= u_i) ? rem_sub : rem_sh;
          end
          default: begin
            phase_nxt = PH_UNARY;
          end
        endcase
      end

      if (fin) begin
        phase_nxt = PH_UNARY;
        qs_nxt    = '0;
        ovf_nxt   = 1'b0;
        rem_nxt   = '0;
        cnt_nxt   = '0;
      end
    end

    ev_nxt.valid = fin;
    ev_nxt.trunc = trunc;
    ev_nxt.ovf   = ovf_r;
    ev_n_nxt     = qs_r + QW'(r_fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_UNARY;
      qs_r    <= '0;
      ovf_r   <= 1'b0;
      rem_r   <= '0;
      cnt_r   <= '0;
      ev_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      qs_r    <= qs_nxt;
      ovf_r   <= ovf_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
      // load while the event slot is empty or moving on
      if (!in_stall) ev_r <= ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) ev_n_r <= ev_n_nxt;
  end

  assign ev_o   = ev_r;
  assign ev_n_o = ev_n_r;

endmodule

### rtl/gbd_out.sv
// ----------------------------------------------------------------------------
// gbd_out
// Truncation flag, range check and signed mapping of N, into the output register.
// ----------------------------------------------------------------------------
module gbd_out
  import gbd_pkg::*;
#(
  parameter int MAPPED_BITS = 17,
  parameter int QW          = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gbd_ev_t                       ev_i,
  input  logic [QW-1:0]                 ev_n_i,
  input  logic                          sign_mode_i,
  output logic                          ev_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [MAPPED_BITS-1:0] out_decoded_value,
  output logic [1:0]                    out_error_code
);

  localparam int MB = MAPPED_BITS;

  logic          out_valid_r;
  logic [MB-1:0] val_r, val_nxt;
  logic [1:0]    err_r, err_nxt;
  logic          ovf_all;
  logic [MB-1:0] half;

  assign ev_ready = !out_valid_r || !out_stall;

  always_comb begin
    ovf_all = ev_i.ovf || (|ev_n_i[QW-1:MB]);
    half    = {1'b0, ev_n_i[MB-1:1]};
    if (ev_i.trunc) begin
      val_nxt = '0;
      err_nxt = ERR_TRUNC;
    end else if (ovf_all) begin
      val_nxt = '0;
      err_nxt = ERR_OVF;
    end else begin
      err_nxt = ERR_OK;
      if (!ev_n_i[0]) val_nxt = half;
      else if (!sign_mode_i) val_nxt = -half;
      else val_nxt = ~half;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ev_ready) begin
      out_valid_r <= ev_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ready && ev_i.valid) begin
      val_r <= val_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_decoded_value = val_r;
  assign out_error_code    = err_r;

endmodule

### rtl/golomb_bit_decoder_top.sv
// ----------------------------------------------------------------------------
// golomb_bit_decoder_top
// Golomb decoder with truncated-binary remainder, one coded bit per beat.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle while in_stall is low.
// The result of a completing beat passes through the event register, then the
//   output register, before out_valid shows it.
// Reset (rst_n low, synchronous): idle between codewords, divisor 3,
//   interleaving mapping, no result pending.
module golomb_bit_decoder_top
  import gbd_pkg::*;
#(
  parameter int MAPPED_BITS  = 17,
  parameter int DIVISOR_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_code_bit,
  input  logic                          in_stream_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [MAPPED_BITS-1:0] out_decoded_value,
  output logic [1:0]                    out_error_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [DIVISOR_BITS-1:0]       cfg_data
);

  localparam int CW = $clog2(DIVISOR_BITS);
  localparam int QW = ((MAPPED_BITS > DIVISOR_BITS) ? MAPPED_BITS : DIVISOR_BITS) + 1;

  logic [DIVISOR_BITS-1:0] m;
  logic [CW-1:0]           k;
  logic [DIVISOR_BITS-1:0] u;
  logic                    sign_mode;
  logic                    ev_ready;
  gbd_ev_t                 ev;
  logic [QW-1:0]           ev_n;

  gbd_cfg #(
    .DIVISOR_BITS (DIVISOR_BITS),
    .CW           (CW)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .m_o         (m),
    .k_o         (k),
    .u_o         (u),
    .sign_mode_o (sign_mode)
  );

  gbd_core #(
    .MAPPED_BITS  (MAPPED_BITS),
    .DIVISOR_BITS (DIVISOR_BITS),
    .CW           (CW),
    .QW           (QW)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_bit   (in_code_bit),
    .in_stream_end (in_stream_end),
    .m_i           (m),
    .k_i           (k),
    .u_i           (u),
    .ev_ready      (ev_ready),
    .ev_o          (ev),
    .ev_n_o        (ev_n)
  );

  gbd_out #(
    .MAPPED_BITS (MAPPED_BITS),
    .QW          (QW)
  ) u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .ev_i              (ev),
    .ev_n_i            (ev_n),
    .sign_mode_i       (sign_mode),
    .ev_ready          (ev_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_decoded_value (out_decoded_value),
    .out_error_code    (out_error_code)
  );

endmodule

### verif/golomb_bit_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// golomb_bit_decoder_top_tb
// Self-checking bench for the Golomb bit decoder.
// A directed bit sequence and then random coded streams run under a series of
// divisor and sign-mode settings. Each phase mixes well-formed codewords,
// stray bits and codewords cut short by an end marker. A bit-level decoder
// model in the bench predicts every result, and the monitor checks the
// results in order against it.
// ----------------------------------------------------------------------------
module golomb_bit_decoder_top_tb;
  import gbd_pkg::*;

  localparam int MB = 17;
  localparam int DB = 16;
  localparam int NUM_PHASES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam longint unsigned N_MAX = (64'd1 << MB) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {ST_UNARY, ST_REM_BITS, ST_EXTRA_BIT} dec_state_t;

  typedef struct packed {
    logic code_bit;
    logic stream_end;
  } code_beat_t;

  typedef struct packed {
    logic [MB-1:0] value;
    logic [1:0]    err;
  } decoded_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_code_bit = 1'b0;
  logic                   in_stream_end = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [MB-1:0]   out_decoded_value;
  logic [1:0]             out_error_code;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DB-1:0]          cfg_data = '0;

  code_beat_t code_beats[$];
  decoded_t   decoded_q[$];
  logic       in_took = 1'b0;
  int         err_count = 0;
  int         cycle_cnt = 0;
  int         hold_req = 0;

  // decoder model state and register copies
  logic [DB-1:0]   div_reg = DB'(DIVISOR_RESET);
  logic            sign_reg = 1'b1;
  dec_state_t      dec_state = ST_UNARY;
  longint unsigned q_acc = 0;
  longint unsigned rem_acc = 0;
  int unsigned     rem_count = 0;
  logic            q_over = 1'b0;

  golomb_bit_decoder_top #(
    .MAPPED_BITS (MB),
    .DIVISOR_BITS(DB)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_bit      (in_code_bit),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_decoded_value(out_decoded_value),
    .out_error_code   (out_error_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned log2_floor(longint unsigned m);
    int unsigned k;
    k = 0;
    while (k < 63 && (m >> (k + 1)) != 0) k++;
    return k;
  endfunction

  function automatic longint unsigned eff_divisor();
    return (div_reg == 0) ? 64'd1 : longint'(div_reg);
  endfunction

  function automatic void clear_word();
    dec_state = ST_UNARY;
    q_acc = 0;
    rem_acc = 0;
    rem_count = 0;
    q_over = 1'b0;
  endfunction

  function automatic void close_word(longint unsigned r);
    longint unsigned n;
    longint unsigned half;
    longint unsigned mapped;
    decoded_t        w;
    n = q_acc + r;
    half = n >> 1;
    if (q_over || n > N_MAX) begin
      w.value = '0;
      w.err = ERR_OVF;
    end else begin
      if (!n[0]) mapped = half;
      else if (!sign_reg) mapped = 64'd0 - half;
      else mapped = ~half;
      w.value = mapped[MB-1:0];
      w.err = ERR_OK;
    end
    decoded_q.push_back(w);
    clear_word();
  endfunction

  // take the plain remainder bits and either close the word or ask for one more
  function automatic void settle_remainder();
    longint unsigned m;
    longint unsigned u;
    m = eff_divisor();
    u = (64'd1 << (log2_floor(m) + 1)) - m;
    if (rem_acc < u) close_word(rem_acc);
    else dec_state = ST_EXTRA_BIT;
  endfunction

  function automatic void decode_step(logic code_bit, logic stream_end);
    longint unsigned m;
    longint unsigned u;
    longint unsigned v2;
    int unsigned     k;
    decoded_t        w;
    m = eff_divisor();
    k = log2_floor(m);
    if (stream_end) begin
      if (dec_state != ST_UNARY || q_acc != 0 || q_over) begin
        w.value = '0;
        w.err = ERR_TRUNC;
        decoded_q.push_back(w);
        clear_word();
      end
    end else begin
      case (dec_state)
        ST_UNARY: begin
          if (code_bit) begin
            if (!q_over) begin
              q_acc += m;
              if (q_acc > N_MAX) q_over = 1'b1;
            end
          end else begin
            rem_acc = 0;
            rem_count = 0;
            dec_state = ST_REM_BITS;
            if (k == 0) settle_remainder();
          end
        end
        ST_REM_BITS: begin
          rem_acc = ((rem_acc << 1) | code_bit) & 64'hFFFF_FFFF;
          rem_count = (rem_count + 1) & 31;
          if (rem_count >= k) settle_remainder();
        end
        default: begin
          u = (64'd1 << (k + 1)) - m;
          v2 = (rem_acc << 1) | code_bit;
          close_word((v2 >= u) ? v2 - u : v2);
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h (cycle %0d)", what, want, got, cycle_cnt);
    err_count++;
  endtask

  // sample handshakes, run the model and check results
  always @(posedge clk) begin : watch
    decoded_t w;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end else begin
      in_took <= rst_n && in_valid && !in_stall;
      if (rst_n) begin
        if (out_valid && !out_stall) begin
          if (decoded_q.size() == 0) begin
            report_mismatch("unexpected result", 0, out_decoded_value);
          end else begin
            w = decoded_q.pop_front();
            if (out_decoded_value !== w.value)
              report_mismatch("decoded_value", w.value, out_decoded_value);
            if (out_error_code !== w.err)
              report_mismatch("error_code", w.err, out_error_code);
          end
        end
        if (in_valid && !in_stall) decode_step(in_code_bit, in_stream_end);
        if (cfg_valid && cfg_ready) begin
          if (cfg_index == CFG_DIVISOR) div_reg = cfg_data;
          else if (cfg_index == CFG_SIGN_MODE) sign_reg = cfg_data[0];
        end
      end
    end
  end

  // sender: bursts of random length, random gaps between them
  int burst_left = 8;
  int gap_left = 0;

  always @(negedge clk) begin : drive
    logic       nv;
    code_beat_t nb;
    nv = in_valid;
    nb = '{code_bit: in_code_bit, stream_end: in_stream_end};
    if (in_took) begin
      nv = 1'b0;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
      end
    end
    if (!nv && rst_n) begin
      if (gap_left > 0) gap_left--;
      else if (code_beats.size() != 0) begin
        nb = code_beats.pop_front();
        nv = 1'b1;
      end
    end
    in_valid <= nv;
    in_code_bit <= nb.code_bit;
    in_stream_end <= nb.stream_end;
  end

  // receiver: stall pattern of its own, plus a long hold on request
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  always @(negedge clk) begin : sink
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic push_bit(logic b);
    code_beats.push_back('{code_bit: b, stream_end: 1'b0});
  endtask

  task automatic push_end();
    code_beats.push_back('{code_bit: 1'($urandom_range(0, 1)), stream_end: 1'b1});
  endtask

  task automatic add_codeword(int unsigned m, int unsigned q, int unsigned r);
    int unsigned k;
    int unsigned u;
    int unsigned val;
    int          nbits;
    k = log2_floor(m);
    u = (1 << (k + 1)) - m;
    repeat (q) push_bit(1'b1);
    push_bit(1'b0);
    if (r < u) begin
      val = r;
      nbits = k;
    end else begin
      val = r + u;
      nbits = k + 1;
    end
    for (int i = nbits - 1; i >= 0; i--) push_bit(1'((val >> i) & 1));
  endtask

  task automatic build_stream(int unsigned divisor, int target);
    int unsigned m;
    int unsigned u;
    int unsigned q;
    int unsigned r;
    int          start;
    int          len;
    int          kind;
    m = (divisor == 0) ? 1 : divisor;
    u = (1 << (log2_floor(m) + 1)) - m;
    start = code_beats.size();
    while (code_beats.size() - start < target) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        push_end();
      end else if (kind == 1) begin
        push_bit(1'($urandom_range(0, 1)));
      end else begin
        if (m >= 20000) q = $urandom_range(0, 4);
        else if ($urandom_range(0, 7) == 0) q = $urandom_range(0, 12);
        else q = $urandom_range(0, 3);
        case ($urandom_range(0, 4))
          0: r = 0;
          1: r = m - 1;
          2: r = u - 1;
          3: r = (u < m) ? u : 0;
          default: r = $urandom_range(0, m - 1);
        endcase
        len = code_beats.size();
        add_codeword(m, q, r);
        // drop a random number of its trailing beats, possibly none, then an end marker
        if (kind == 2) begin
          len = code_beats.size() - len;
          repeat ($urandom_range(0, len - 1)) void'(code_beats.pop_back());
          push_end();
        end
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DB-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    int waited;
    while (code_beats.size() != 0 || in_valid) @(posedge clk);
    waited = 0;
    while (decoded_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (decoded_q.size() != 0) begin
      report_mismatch("missing results", decoded_q.size(), 0);
      decoded_q.delete();
    end
    // a codeword may still be in flight without a result
    repeat (6) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned divs[NUM_PHASES];
    logic        signs[NUM_PHASES];
    divs = '{1, 65535, 0, 2, 4, 5, 7, 65535, 40000, 0, 0, 0};
    signs = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    divs[9] = $urandom_range(8, 300);
    divs[10] = $urandom_range(1, 65535);
    divs[11] = $urandom_range(3, 40);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset setting m = 3, interleaved: idle end marker, short codewords,
    // end marker after unary ones, in the remainder and before the extra bit
    push_end();
    push_bit(1'b0); push_bit(1'b0);
    push_bit(1'b0); push_bit(1'b1); push_bit(1'b0);
    push_bit(1'b0); push_bit(1'b1); push_bit(1'b1);
    push_bit(1'b1); push_bit(1'b1); push_bit(1'b0); push_bit(1'b1); push_bit(1'b1);
    push_bit(1'b1); push_end();
    push_bit(1'b0); push_end();
    push_bit(1'b0); push_bit(1'b1); push_end();
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_DIVISOR, DB'(divs[ph]));
      write_reg(CFG_SIGN_MODE, DB'(($urandom & 16'hFFFE) | signs[ph]));
      if (ph == 5) write_reg(CFG_SPARE, DB'($urandom));
      build_stream(divs[ph], (ph == 3) ? 160 : 85);
      // hold off the receiver while the sender keeps offering beats
      if (ph == 3) hold_req++;
      drain();
    end

    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### golomb_bit_decoder_top.f
rtl/gbd_pkg.sv
rtl/gbd_cfg.sv
rtl/gbd_core.sv
rtl/gbd_out.sv
rtl/golomb_bit_decoder_top.sv
verif/golomb_bit_decoder_top_tb.sv
